@@ design/aars_pkg.sv @@
// types and constants shared by the accelerating auto-repeat setter
// no dependencies
`timescale 1ns / 1ps

package aars_pkg;

    typedef struct packed {
        logic               command;
        logic signed [15:0] start_value;
        logic               up_touched;
        logic               down_touched;
        logic               ok_touched;
    } item_t;

    typedef struct packed {
        logic signed [15:0] current_value;
        logic               changed;
        logic               finished;
        logic               rejected;
    } result_t;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_WAIT = 5'b00010,
        MODE_UP   = 5'b00100,
        MODE_DOWN = 5'b01000,
        MODE_OK   = 5'b10000
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MIN_VALUE = 2'd0,
        CFG_MAX_VALUE = 2'd1,
        CFG_STEP_SIZE = 2'd2
    } cfg_index_t;

    localparam logic [9:0] REPEAT_DELAY_TICKS = 10'd500;
    localparam logic [6:0] RELEASE_TICKS      = 7'd100;
    localparam logic [6:0] START_INTERVAL     = 7'd100;
    localparam logic [6:0] MIN_INTERVAL       = 7'd10;
    localparam logic [9:0] HELD_MAX           = 10'd1023;
    localparam logic [6:0] COUNT_MAX          = 7'd127;

    localparam logic [6:0] FAST_BOUND_1 = START_INTERVAL - 7'd8;
    localparam logic [6:0] FAST_BOUND_2 = START_INTERVAL - 7'd16;
    localparam logic [6:0] FAST_BOUND_3 = START_INTERVAL - 7'd32;

    localparam logic signed [15:0] MIN_VALUE_RESET = 16'sd0;
    localparam logic signed [15:0] MAX_VALUE_RESET = 16'sd1000;
    localparam logic [7:0]         STEP_SIZE_RESET = 8'd1;

endpackage

@@ design/accelerating_auto_repeat_setter.sv @@
// channel  | signals                            | word
// ---------+------------------------------------+-----------------
// item     | item_valid, item_stall, item       | aars_pkg::item_t
// result   | result_valid, result_stall, result | aars_pkg::result_t
// cfg      | cfg_valid, cfg_ready, cfg_index    | cfg_data (16 bit)
//
// one word per cycle sustained while the result is not stalled
// the word sits in an input register, then one pass of compare/add logic updates the
// session state and the result register together
// reset puts the session in idle with value zero and limits 0 / 1000, step 1
// a stalled result holds the pipe; the input register still takes one more word if it is empty
// depends on aars_pkg
`timescale 1ns / 1ps

module accelerating_auto_repeat_setter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  aars_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output aars_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import aars_pkg::*;

    logic               stage_valid_reg;
    item_t              stage_reg;
    logic               result_valid_reg;
    result_t            result_reg;

    logic signed [15:0] min_value_reg;
    logic signed [15:0] max_value_reg;
    logic [7:0]         step_size_reg;

    mode_t              mode_reg;
    mode_t              mode_next;
    logic signed [15:0] value_reg;
    logic signed [15:0] value_next;
    logic [9:0]         held_reg;
    logic [9:0]         held_next;
    logic [6:0]         since_reg;
    logic [6:0]         since_next;
    logic [6:0]         untouched_reg;
    logic [6:0]         untouched_next;
    logic [6:0]         interval_reg;
    logic [6:0]         interval_next;

    logic               move;
    logic               fire;
    logic               own;
    logic [9:0]         held_inc;
    logic [6:0]         since_inc;
    logic [6:0]         untouched_inc;
    logic [6:0]         need;
    logic [7:0]         interval_dec;
    logic [7:0]         fast_amount;
    logic [6:0]         interval_fast;
    logic signed [16:0] value_ext;
    logic signed [16:0] step_ext;
    logic signed [16:0] sum_w;
    logic signed [16:0] diff_w;
    logic signed [15:0] up_value;
    logic signed [15:0] down_value;
    logic               up_can;
    logic               down_can;
    logic               step_req;
    logic               step_dir_up;
    logic               changed;
    logic               finished;
    logic               rejected;

    assign move       = !result_valid_reg || !result_stall;
    assign fire       = stage_valid_reg && move;
    assign item_stall = stage_valid_reg && !move;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // per-tick counters
    always_comb
    begin
        unique case (mode_reg)
            MODE_UP:   own = stage_reg.up_touched;
            MODE_DOWN: own = stage_reg.down_touched;
            default:   own = stage_reg.ok_touched;
        endcase
        held_inc      = (held_reg < HELD_MAX) ? held_reg + 10'd1 : held_reg;
        since_inc     = (since_reg < COUNT_MAX) ? since_reg + 7'd1 : since_reg;
        untouched_inc = own ? 7'd0
                      : ((untouched_reg < COUNT_MAX) ? untouched_reg + 7'd1 : untouched_reg);
        need          = (interval_reg == COUNT_MAX) ? COUNT_MAX : interval_reg + 7'd1;
    end

    // repeat interval speed-up
    always_comb
    begin
        priority if (interval_reg > FAST_BOUND_1)
            fast_amount = 8'd1;
        else if (interval_reg > FAST_BOUND_2)
            fast_amount = 8'd2;
        else if (interval_reg > FAST_BOUND_3)
            fast_amount = 8'd4;
        else
            fast_amount = 8'd8;
        interval_dec  = {1'b0, interval_reg} - fast_amount;
        interval_fast = (interval_dec[7] || interval_dec[6:0] < MIN_INTERVAL)
                      ? MIN_INTERVAL : interval_dec[6:0];
    end

    // saturating step adder
    always_comb
    begin
        value_ext  = {value_reg[15], value_reg};
        step_ext   = {9'b0, step_size_reg};
        sum_w      = value_ext + step_ext;
        diff_w     = value_ext - step_ext;
        up_value   = (sum_w[16] != sum_w[15]) ? 16'sh7fff : sum_w[15:0];
        down_value = (diff_w[16] != diff_w[15]) ? 16'sh8000 : diff_w[15:0];
        up_can     = value_reg < max_value_reg;
        down_can   = value_reg > min_value_reg;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        value_next     = value_reg;
        held_next      = held_reg;
        since_next     = since_reg;
        untouched_next = untouched_reg;
        interval_next  = interval_reg;
        changed        = 1'b0;
        finished       = 1'b0;
        rejected       = 1'b0;
        step_req       = 1'b0;
        step_dir_up    = 1'b0;

        if (stage_reg.command)
        begin
            if (stage_reg.start_value[15])
            begin
                rejected  = 1'b1;
                finished  = 1'b1;
                mode_next = MODE_IDLE;
            end
            else
            begin
                value_next     = stage_reg.start_value;
                mode_next      = MODE_WAIT;
                held_next      = '0;
                since_next     = '0;
                untouched_next = '0;
                interval_next  = START_INTERVAL;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                end
                MODE_WAIT:
                begin
                    if (stage_reg.up_touched || stage_reg.down_touched
                        || stage_reg.ok_touched)
                    begin
                        held_next      = '0;
                        since_next     = '0;
                        untouched_next = '0;
                        interval_next  = START_INTERVAL;
                    end
                    priority if (stage_reg.up_touched)
                    begin
                        mode_next   = MODE_UP;
                        step_req    = 1'b1;
                        step_dir_up = 1'b1;
                    end
                    else if (stage_reg.down_touched)
                    begin
                        mode_next = MODE_DOWN;
                        step_req  = 1'b1;
                    end
                    else if (stage_reg.ok_touched)
                        mode_next = MODE_OK;
                    else
                    begin
                    end
                end
                MODE_UP, MODE_DOWN, MODE_OK:
                begin
                    held_next      = held_inc;
                    since_next     = since_inc;
                    untouched_next = untouched_inc;
                    if (untouched_inc > RELEASE_TICKS)
                    begin
                        if (mode_reg == MODE_OK)
                        begin
                            finished  = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                        else
                            mode_next = MODE_WAIT;
                    end
                    else if (mode_reg != MODE_OK && held_inc > REPEAT_DELAY_TICKS
                             && since_inc >= need)
                    begin
                        since_next    = '0;
                        step_req      = 1'b1;
                        step_dir_up   = (mode_reg == MODE_UP);
                        interval_next = interval_fast;
                    end
                end
                default:
                    mode_next = MODE_IDLE;
            endcase
        end

        if (step_req)
        begin
            if (step_dir_up && up_can)
            begin
                value_next = up_value;
                changed    = 1'b1;
            end
            else if (!step_dir_up && down_can)
            begin
                value_next = down_value;
                changed    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!item_stall)
                stage_valid_reg <= item_valid;
            if (move)
                result_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
            stage_reg <= item;
        if (fire)
        begin
            result_reg.current_value <= value_next;
            result_reg.changed       <= changed;
            result_reg.finished      <= finished;
            result_reg.rejected      <= rejected;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_value_reg <= MIN_VALUE_RESET;
            max_value_reg <= MAX_VALUE_RESET;
            step_size_reg <= STEP_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_VALUE: min_value_reg <= cfg_data;
                CFG_MAX_VALUE: max_value_reg <= cfg_data;
                CFG_STEP_SIZE: step_size_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            value_reg     <= '0;
            held_reg      <= '0;
            since_reg     <= '0;
            untouched_reg <= '0;
            interval_reg  <= START_INTERVAL;
        end
        else if (fire)
        begin
            mode_reg      <= mode_next;
            value_reg     <= value_next;
            held_reg      <= held_next;
            since_reg     <= since_next;
            untouched_reg <= untouched_next;
            interval_reg  <= interval_next;
        end
    end

`ifndef ASSERT_OFF
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> stage_valid_reg)
        else $error("item stalled with empty input register");

    a_reject_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (!result_reg.rejected || (result_reg.finished
                                                       && !result_reg.changed)))
        else $error("rejected start without finish or with a step");

    a_interval_range: assert property (@(posedge clk) disable iff (!rst_n)
        (interval_reg >= MIN_INTERVAL) && (interval_reg <= START_INTERVAL))
        else $error("repeat interval out of range");

    a_untouched_bound: assert property (@(posedge clk) disable iff (!rst_n)
        untouched_reg <= RELEASE_TICKS + 7'd1)
        else $error("untouched counter ran past release");
`endif

endmodule
